// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker file of the half-shell neighbor block.
// Depends on nothing; included by the checker with `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, quiet while reset is asserted
`define HSN_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("hsn checker: property violated");

// Clocked assertion that also holds across reset
`define HSN_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("hsn checker: reset property violated");

`endif

// ===== hdl/hsn_pkg.sv =====
// Package of the half-shell neighbor cell generator: widths, codes, microcode
// types, the control store and small arithmetic helpers. Depends on nothing.
package hsn_pkg;

    // Field and register widths
    localparam int GRID_W     = 7;
    localparam int CELL_W     = 6;
    localparam int PLANE_W    = 2;
    localparam int INDEX_W    = 18;
    localparam int CODE_W     = 5;
    localparam int REACH_W    = 2;
    localparam int OFF_W      = 3;
    localparam int SUM_W      = 9;
    localparam int NXY_W      = 2 * GRID_W;
    localparam int PROD_W     = NXY_W + GRID_W;
    localparam int STEP_W     = 3;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 24;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // Register indexes on the configuration port (word address)
    localparam logic [1:0] REG_GRID_X = 2'd0;
    localparam logic [1:0] REG_GRID_Y = 2'd1;
    localparam logic [1:0] REG_GRID_Z = 2'd2;

    // Periodic shift codes per axis
    localparam logic [1:0] SHIFT_NEG  = 2'd0;
    localparam logic [1:0] SHIFT_NONE = 2'd1;
    localparam logic [1:0] SHIFT_POS  = 2'd2;

    // Weights of the translate code
    localparam int AXIS_CODES  = 3;
    localparam int Z_CODE_STEP = 9;

    localparam logic [REACH_W-1:0] REACH_MIN = 2'd1;

    // Effective grid geometry
    typedef struct packed {
        logic [GRID_W-1:0]  nx;
        logic [GRID_W-1:0]  ny;
        logic [GRID_W-1:0]  nz;
        logic [REACH_W-1:0] rx;
        logic [REACH_W-1:0] ry;
        logic [REACH_W-1:0] rz;
    } geom_t;

    // One wrapped coordinate and its shift code
    typedef struct packed {
        logic [GRID_W-1:0] coord;
        logic [1:0]        shift;
    } wrap_t;

    // Microcode fields
    typedef enum logic [1:0] {MUL_NONE, MUL_NXY, MUL_ZBASE, MUL_YBASE} mul_op_t;
    typedef enum logic [1:0] {OFF_HOLD, OFF_HOME, OFF_PATCH} off_op_t;
    typedef enum logic [1:0] {OUT_NONE, OUT_CELL, OUT_BEYOND} out_op_t;
    typedef enum logic [2:0] {J_NEXT, J_GOTO, J_ACCEPT, J_PLANE, J_SENT} jmp_t;

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t ST_IDLE   = 3'd0;
    localparam step_t ST_DECODE = 3'd1;
    localparam step_t ST_HOME   = 3'd2;
    localparam step_t ST_PATCH  = 3'd3;
    localparam step_t ST_ZBASE  = 3'd4;
    localparam step_t ST_YBASE  = 3'd5;
    localparam step_t ST_EMIT   = 3'd6;
    localparam step_t ST_BEYOND = 3'd7;

    typedef struct packed {
        logic    in_ready;
        mul_op_t mul_op;
        off_op_t off_op;
        out_op_t out_op;
        jmp_t    jmp;
        step_t   target;
    } ucode_t;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic accept;
        logic plane_zero;
        logic plane_in_reach;
        logic final_sent;
    } dp_status_t;

    // Control store: one word per step
    function automatic ucode_t ucode_rom(input step_t s);
        ucode_t w;
        w = '{in_ready: 1'b1, mul_op: MUL_NONE, off_op: OFF_HOLD, out_op: OUT_NONE,
              jmp: J_ACCEPT, target: ST_DECODE};
        unique case (s)
            ST_IDLE:   w = '{in_ready: 1'b1, mul_op: MUL_NONE, off_op: OFF_HOLD,
                             out_op: OUT_NONE, jmp: J_ACCEPT, target: ST_DECODE};
            ST_DECODE: w = '{in_ready: 1'b0, mul_op: MUL_NXY, off_op: OFF_HOLD,
                             out_op: OUT_NONE, jmp: J_PLANE, target: ST_IDLE};
            ST_HOME:   w = '{in_ready: 1'b0, mul_op: MUL_NONE, off_op: OFF_HOME,
                             out_op: OUT_NONE, jmp: J_GOTO, target: ST_ZBASE};
            ST_PATCH:  w = '{in_ready: 1'b0, mul_op: MUL_NONE, off_op: OFF_PATCH,
                             out_op: OUT_NONE, jmp: J_NEXT, target: ST_ZBASE};
            ST_ZBASE:  w = '{in_ready: 1'b0, mul_op: MUL_ZBASE, off_op: OFF_HOLD,
                             out_op: OUT_NONE, jmp: J_NEXT, target: ST_YBASE};
            ST_YBASE:  w = '{in_ready: 1'b0, mul_op: MUL_YBASE, off_op: OFF_HOLD,
                             out_op: OUT_NONE, jmp: J_NEXT, target: ST_EMIT};
            ST_EMIT:   w = '{in_ready: 1'b0, mul_op: MUL_NONE, off_op: OFF_HOLD,
                             out_op: OUT_CELL, jmp: J_SENT, target: ST_IDLE};
            ST_BEYOND: w = '{in_ready: 1'b0, mul_op: MUL_NONE, off_op: OFF_HOLD,
                             out_op: OUT_BEYOND, jmp: J_SENT, target: ST_IDLE};
            default:   w = '{in_ready: 1'b1, mul_op: MUL_NONE, off_op: OFF_HOLD,
                             out_op: OUT_NONE, jmp: J_ACCEPT, target: ST_DECODE};
        endcase
        return w;
    endfunction

    // Grid size as used: zero reads as one, clamp to the largest grid
    function automatic logic [GRID_W-1:0] eff_size(input logic [GRID_W-1:0] v,
                                                    input int max_grid);
        logic [GRID_W-1:0] n;
        n = v;
        if (v == '0)
            n = GRID_W'(1);
        else if (int'(v) > max_grid)
            n = GRID_W'(max_grid);
        return n;
    endfunction

    // Reach per axis, cut back on small grids
    function automatic logic [REACH_W-1:0] eff_reach(input logic [GRID_W-1:0] n,
                                                      input logic [REACH_W-1:0] max_off);
        logic [GRID_W:0]   half_up;
        logic [GRID_W-2:0] half;
        logic [REACH_W-1:0] r;
        half_up = ({1'b0, n} + (GRID_W+1)'(1)) >> 1;
        half    = n[GRID_W-1:1];
        r       = max_off;
        if (half_up <= (GRID_W+1)'(max_off)) begin
            if (half <= (GRID_W-1)'(2))
                r = REACH_MIN;
            else
                r = REACH_W'(half - (GRID_W-1)'(1));
        end
        return r;
    endfunction

    // Saturate a home coordinate below the grid size
    function automatic logic [CELL_W-1:0] sat_cell(input logic [CELL_W-1:0] c,
                                                    input logic [GRID_W-1:0] n);
        logic [CELL_W-1:0] r;
        r = c;
        if ({1'b0, c} >= n)
            r = CELL_W'(n - GRID_W'(1));
        return r;
    endfunction

    // Wrap a coordinate by at most one period
    function automatic wrap_t wrap1(input logic signed [SUM_W-1:0] c,
                                    input logic [GRID_W-1:0] n);
        wrap_t w;
        logic signed [SUM_W-1:0] ns;
        ns = $signed({{(SUM_W-GRID_W){1'b0}}, n});
        if (c < 0) begin
            w.coord = GRID_W'(c + ns);
            w.shift = SHIFT_NEG;
        end else if (c < ns) begin
            w.coord = GRID_W'(c);
            w.shift = SHIFT_NONE;
        end else begin
            w.coord = GRID_W'(c - ns);
            w.shift = SHIFT_POS;
        end
        return w;
    endfunction

endpackage

// ===== hdl/hsn_cfg.sv =====
// Configuration registers of the half-shell neighbor block on an APB-style port,
// and the effective geometry derived from them. Depends on hsn_pkg.
module hsn_cfg #(
    parameter int MAX_GRID   = 64,
    parameter int MAX_OFFSET = 3
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [hsn_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [hsn_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [hsn_pkg::CFG_DATA_W-1:0]   prdata,
    output hsn_pkg::geom_t                   geom
);

    logic [hsn_pkg::GRID_W-1:0] grid_x_reg, grid_y_reg, grid_z_reg;
    logic [hsn_pkg::GRID_W-1:0] grid_x_next, grid_y_next, grid_z_next;
    logic [1:0]                 reg_sel;
    logic                       wr_en;

    assign reg_sel = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    // Decode writes
    always_comb
    begin
        grid_x_next = grid_x_reg;
        grid_y_next = grid_y_reg;
        grid_z_next = grid_z_reg;
        if (wr_en) begin
            unique case (reg_sel)
                hsn_pkg::REG_GRID_X: grid_x_next = pwdata[hsn_pkg::GRID_W-1:0];
                hsn_pkg::REG_GRID_Y: grid_y_next = pwdata[hsn_pkg::GRID_W-1:0];
                hsn_pkg::REG_GRID_Z: grid_z_next = pwdata[hsn_pkg::GRID_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            grid_x_reg <= hsn_pkg::GRID_W'(1);
            grid_y_reg <= hsn_pkg::GRID_W'(1);
            grid_z_reg <= hsn_pkg::GRID_W'(1);
        end else begin
            grid_x_reg <= grid_x_next;
            grid_y_reg <= grid_y_next;
            grid_z_reg <= grid_z_next;
        end
    end

    // Read back
    always_comb
    begin
        unique case (reg_sel)
            hsn_pkg::REG_GRID_X: prdata = hsn_pkg::CFG_DATA_W'(grid_x_reg);
            hsn_pkg::REG_GRID_Y: prdata = hsn_pkg::CFG_DATA_W'(grid_y_reg);
            hsn_pkg::REG_GRID_Z: prdata = hsn_pkg::CFG_DATA_W'(grid_z_reg);
            default:             prdata = '0;
        endcase
    end

    // Effective sizes and reaches
    always_comb
    begin
        geom.nx = hsn_pkg::eff_size(grid_x_reg, MAX_GRID);
        geom.ny = hsn_pkg::eff_size(grid_y_reg, MAX_GRID);
        geom.nz = hsn_pkg::eff_size(grid_z_reg, MAX_GRID);
        geom.rx = hsn_pkg::eff_reach(geom.nx, hsn_pkg::REACH_W'(MAX_OFFSET));
        geom.ry = hsn_pkg::eff_reach(geom.ny, hsn_pkg::REACH_W'(MAX_OFFSET));
        geom.rz = hsn_pkg::eff_reach(geom.nz, hsn_pkg::REACH_W'(MAX_OFFSET));
    end

endmodule

// ===== hdl/hsn_seq.sv =====
// Microcode sequencer of the half-shell neighbor block: step counter, control
// store lookup and conditional jumps. Depends on hsn_pkg.
module hsn_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  hsn_pkg::dp_status_t status,
    output hsn_pkg::ucode_t     uc
);

    hsn_pkg::step_t step_reg, step_next;

    assign uc = hsn_pkg::ucode_rom(step_reg);

    // Pick the next step
    always_comb
    begin
        unique case (uc.jmp)
            hsn_pkg::J_NEXT:   step_next = step_reg + hsn_pkg::STEP_W'(1);
            hsn_pkg::J_GOTO:   step_next = uc.target;
            hsn_pkg::J_ACCEPT: step_next = status.accept ? uc.target : step_reg;
            hsn_pkg::J_PLANE:
            begin
                if (status.plane_zero)
                    step_next = hsn_pkg::ST_HOME;
                else if (status.plane_in_reach)
                    step_next = hsn_pkg::ST_PATCH;
                else
                    step_next = hsn_pkg::ST_BEYOND;
            end
            hsn_pkg::J_SENT:   step_next = status.final_sent ? uc.target : step_reg;
            default:           step_next = hsn_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= hsn_pkg::ST_IDLE;
        else
            step_reg <= step_next;
    end

endmodule

// ===== hdl/hsn_dp.sv =====
// Datapath of the half-shell neighbor block: input latch, offset counters,
// shared multiplier, index assembly and output register. Depends on hsn_pkg.
module hsn_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  hsn_pkg::geom_t                  geom,
    input  hsn_pkg::ucode_t                 uc,
    input  logic                            s_tvalid,
    input  logic [hsn_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            m_tready,
    output hsn_pkg::dp_status_t             status,
    output logic                            m_tvalid,
    output logic [hsn_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tuser,
    output logic                            m_tlast
);

    localparam int CW = hsn_pkg::CELL_W;
    localparam int GW = hsn_pkg::GRID_W;
    localparam int SW = hsn_pkg::SUM_W;
    localparam int OW = hsn_pkg::OFF_W;
    localparam int IW = hsn_pkg::INDEX_W;

    // Home cell and plane
    logic [CW-1:0] cx_reg, cy_reg, cz_reg, cx_next, cy_next, cz_next;
    logic [hsn_pkg::PLANE_W-1:0] plane_reg, plane_next;
    // Running offsets
    logic signed [OW-1:0] dx_reg, dy_reg, dx_next, dy_next;
    logic [hsn_pkg::PLANE_W-1:0] dz_reg, dz_next;
    // Bases from the shared multiplier
    logic [hsn_pkg::NXY_W-1:0] nxy_reg, nxy_next, ybase_reg, ybase_next;
    logic [IW-1:0]             zbase_reg, zbase_next;
    // Output register
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [IW-1:0]               index_reg, index_next;
    logic [hsn_pkg::CODE_W-1:0]  code_reg, code_next;
    logic                        vres_reg, vres_next;
    logic                        last_reg, last_next;

    logic                        accept, slot_free, x_end, y_end, emit;
    logic signed [SW-1:0]        sx, sy, sy_up, sz;
    hsn_pkg::wrap_t              wx, wy, wy_up, wz;
    logic [hsn_pkg::NXY_W-1:0]   mul_a;
    logic [GW-1:0]               mul_b;
    logic [hsn_pkg::PROD_W-1:0]  prod;
    logic [hsn_pkg::CODE_W-1:0]  cell_code;
    logic [IW-1:0]               cell_index;
    logic signed [OW-1:0]        neg_rx, neg_ry;

    assign accept    = s_tvalid && uc.in_ready;
    assign slot_free = !m_tvalid_reg || m_tready;
    assign neg_rx    = OW'(0) - $signed({1'b0, geom.rx});
    assign neg_ry    = OW'(0) - $signed({1'b0, geom.ry});
    assign x_end     = (dx_reg == $signed({1'b0, geom.rx}));
    assign y_end     = (dy_reg == $signed({1'b0, geom.ry}));
    assign emit      = (uc.out_op == hsn_pkg::OUT_CELL) && slot_free;

    // Wrapped coordinates of the current neighbor and of the next row
    always_comb
    begin
        sx    = $signed({{(SW-CW){1'b0}}, cx_reg}) + SW'(dx_reg);
        sy    = $signed({{(SW-CW){1'b0}}, cy_reg}) + SW'(dy_reg);
        sy_up = sy + SW'(1);
        sz    = $signed({{(SW-CW){1'b0}}, cz_reg})
                + $signed({{(SW-hsn_pkg::PLANE_W){1'b0}}, dz_reg});
        wx    = hsn_pkg::wrap1(sx, geom.nx);
        wy    = hsn_pkg::wrap1(sy, geom.ny);
        wy_up = hsn_pkg::wrap1(sy_up, geom.ny);
        wz    = hsn_pkg::wrap1(sz, geom.nz);
    end

    // Translate code and linear index
    always_comb
    begin
        cell_code  = ((wz.shift == hsn_pkg::SHIFT_POS)
                        ? hsn_pkg::CODE_W'(hsn_pkg::Z_CODE_STEP) : '0)
                     + hsn_pkg::CODE_W'(wy.shift * hsn_pkg::AXIS_CODES)
                     + hsn_pkg::CODE_W'(wx.shift);
        cell_index = zbase_reg + IW'(ybase_reg) + IW'(wx.coord);
    end

    // Shared multiplier: operands chosen by the control word
    always_comb
    begin
        unique case (uc.mul_op)
            hsn_pkg::MUL_NXY:
            begin
                mul_a = hsn_pkg::NXY_W'(geom.nx);
                mul_b = geom.ny;
            end
            hsn_pkg::MUL_ZBASE:
            begin
                mul_a = nxy_reg;
                mul_b = wz.coord;
            end
            hsn_pkg::MUL_YBASE:
            begin
                mul_a = hsn_pkg::NXY_W'(geom.nx);
                mul_b = wy.coord;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = hsn_pkg::PROD_W'(mul_a) * hsn_pkg::PROD_W'(mul_b);
    end

    // Status to the sequencer
    always_comb
    begin
        status.accept         = accept;
        status.plane_zero     = (plane_reg == '0);
        status.plane_in_reach = (plane_reg <= geom.rz);
        status.final_sent     = slot_free
                                && ((uc.out_op == hsn_pkg::OUT_BEYOND)
                                    || ((uc.out_op == hsn_pkg::OUT_CELL) && x_end && y_end));
    end

    // Next values of the working registers
    always_comb
    begin
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        cz_next    = cz_reg;
        plane_next = plane_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        dz_next    = dz_reg;
        nxy_next   = nxy_reg;
        zbase_next = zbase_reg;
        ybase_next = ybase_reg;

        // Latch the home cell, saturated into the grid
        if (accept) begin
            cx_next    = hsn_pkg::sat_cell(s_tdata[CW-1:0], geom.nx);
            cy_next    = hsn_pkg::sat_cell(s_tdata[2*CW-1:CW], geom.ny);
            cz_next    = hsn_pkg::sat_cell(s_tdata[3*CW-1:2*CW], geom.nz);
            plane_next = s_tdata[3*CW+hsn_pkg::PLANE_W-1:3*CW];
        end

        // Load the offsets at the start of a plane
        case (uc.off_op)
            hsn_pkg::OFF_HOME:
            begin
                dx_next = '0;
                dy_next = '0;
                dz_next = '0;
            end
            hsn_pkg::OFF_PATCH:
            begin
                dx_next = neg_rx;
                dy_next = neg_ry;
                dz_next = plane_reg;
            end
            default: ;
        endcase

        // Capture the multiplier result
        case (uc.mul_op)
            hsn_pkg::MUL_NXY:   nxy_next   = prod[hsn_pkg::NXY_W-1:0];
            hsn_pkg::MUL_ZBASE: zbase_next = prod[IW-1:0];
            hsn_pkg::MUL_YBASE: ybase_next = prod[hsn_pkg::NXY_W-1:0];
            default: ;
        endcase

        // Advance x, then the row; the row base steps by nx or wraps to zero
        if (emit) begin
            if (!x_end) begin
                dx_next = dx_reg + OW'(1);
            end else begin
                dx_next    = neg_rx;
                dy_next    = dy_reg + OW'(1);
                ybase_next = (wy_up.coord == '0) ? '0
                             : ybase_reg + hsn_pkg::NXY_W'(geom.nx);
            end
        end
    end

    // Output register
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        index_next    = index_reg;
        code_next     = code_reg;
        vres_next     = vres_reg;
        last_next     = last_reg;
        if (slot_free && (uc.out_op == hsn_pkg::OUT_CELL)) begin
            m_tvalid_next = 1'b1;
            index_next    = cell_index;
            code_next     = cell_code;
            vres_next     = 1'b1;
            last_next     = x_end && y_end;
        end else if (slot_free && (uc.out_op == hsn_pkg::OUT_BEYOND)) begin
            m_tvalid_next = 1'b1;
            index_next    = '0;
            code_next     = '0;
            vres_next     = 1'b0;
            last_next     = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else
            m_tvalid_reg <= m_tvalid_next;
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        cz_reg    <= cz_next;
        plane_reg <= plane_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        dz_reg    <= dz_next;
        nxy_reg   <= nxy_next;
        zbase_reg <= zbase_next;
        ybase_reg <= ybase_next;
        index_reg <= index_next;
        code_reg  <= code_next;
        vres_reg  <= vres_next;
        last_reg  <= last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = hsn_pkg::M_TDATA_W'({code_reg, index_reg});
    assign m_tuser  = vres_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== hdl/half_shell_neighbor_cell_gen.sv =====
// Top level of the half-shell neighbor cell generator: configuration port,
// microcode sequencer and datapath. Depends on hsn_pkg, hsn_cfg, hsn_seq, hsn_dp.
//
//   Port group   Direction  Carries
//   ----------   ---------  ---------------------------------------------------
//   s_t*         in         home cell and plane, one word per item
//   m_t*         out        neighbor index, translate code, valid flag, last
//   p*           in/out     grid_x / grid_y / grid_z at 0x0 / 0x4 / 0x8
//
// An item runs through setup steps (accept, decode, offset load, two base
// products on the one shared multiplier), then the emit step sends the results
// of the plane one after another; a plane beyond the z reach gives one empty result.
// Reset clears the step counter, output valid and the grid registers to 1.
// A low m_tready holds the emit step; s_tready is high only in the idle step.
module half_shell_neighbor_cell_gen #(
    parameter int MAX_GRID   = 64,
    parameter int MAX_OFFSET = 3
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [hsn_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [hsn_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [hsn_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready,
    // input items
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // cell_x[5:0], cell_y[11:6], cell_z[17:12], plane[19:18], zero fill
    input  logic [hsn_pkg::S_TDATA_W-1:0]    s_tdata,
    // results
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // neighbor_index[17:0], translate_code[22:18], zero fill
    output logic [hsn_pkg::M_TDATA_W-1:0]    m_tdata,
    // valid_res[0]
    output logic                             m_tuser,
    output logic                             m_tlast
);

    hsn_pkg::geom_t      geom;
    hsn_pkg::ucode_t     uc;
    hsn_pkg::dp_status_t status;

    assign pready   = 1'b1;
    assign s_tready = uc.in_ready;

    hsn_cfg #(
        .MAX_GRID   (MAX_GRID),
        .MAX_OFFSET (MAX_OFFSET)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .geom    (geom)
    );

    hsn_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .uc     (uc)
    );

    hsn_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .geom     (geom),
        .uc       (uc),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== hdl/hsn_checker.sv =====
// Port-level checker of the half-shell neighbor block and its bind.
// Depends on assert_macros.svh and the top level half_shell_neighbor_cell_gen.
`include "assert_macros.svh"

module hsn_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // Drop valid while reset is low
    `HSN_ASSERT_ALWAYS(a_reset_clears_out, clk, !rst_n |=> !m_tvalid)

    // Hold a stalled result
    `HSN_ASSERT(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

    // One item at a time: no accept right after an accept
    `HSN_ASSERT(a_one_item, clk, rst_n, s_tvalid && s_tready |=> !s_tready)

    // A plane beyond reach gives one empty, final result
    `HSN_ASSERT(a_beyond_form, clk, rst_n, m_tvalid && !m_tuser |-> m_tlast && m_tdata == 24'd0)

    // Translate codes stay within the eighteen images
    `HSN_ASSERT(a_code_range, clk, rst_n, m_tvalid |-> m_tdata[22:18] <= 5'd17)

endmodule

bind half_shell_neighbor_cell_gen hsn_checker u_hsn_checker (.*);
